@@ rtl/core/bgbg_pkg.sv @@
// bgbg_pkg: shared types and codes for the button gesture bar graph
// holds the gesture state enum, gesture codes and register indexes
// no dependencies
package bgbg_pkg;

	// gesture classifier states
	typedef enum logic [3:0] {
		ST_IDLE       = 4'd0,
		ST_PRESS1     = 4'd1,
		ST_GAP_SHORT  = 4'd2,
		ST_PRESS2_S   = 4'd3,
		ST_SHORT_LONG = 4'd4,
		ST_LONG_HELD  = 4'd5,
		ST_GAP_LONG   = 4'd6,
		ST_PRESS2_L   = 4'd7,
		ST_LONG_LONG  = 4'd8
	} gest_state_t;

	// completed gesture codes
	typedef enum logic [2:0] {
		GEST_NONE        = 3'd0,
		GEST_SHORT       = 3'd1,
		GEST_SHORT_SHORT = 3'd2,
		GEST_SHORT_LONG  = 3'd3,
		GEST_LONG        = 3'd4,
		GEST_LONG_SHORT  = 3'd5,
		GEST_LONG_LONG   = 3'd6
	} gesture_t;

	// configuration register indexes
	localparam logic [1:0] REG_HOLD_TICKS = 2'd0;
	localparam logic [1:0] REG_GAP_TICKS  = 2'd1;

	localparam int TIMER_W = 16;
	localparam logic [TIMER_W-1:0] TIMER_MAX = '1;
	localparam logic [TIMER_W-1:0] TICKS_RESET = 16'd200;

	// bar presets before clamping to the bar length
	localparam int PRESET_SHORT_LONG = 6;
	localparam int PRESET_LONG       = 8;

endpackage

@@ rtl/core/button_gesture_bar_graph.sv @@
// button_gesture_bar_graph: classifies button press gestures per tick and
// drives a thermometer bar graph; depends on bgbg_pkg
// An accepted tick word's result word is registered and is offered in the following cycle.
// Throughput: one tick word per cycle while the downstream keeps taking results;
// the state update and bar logic are combinational, and the output register lets a
// new word enter while the previous result waits, as long as the downstream takes it in that cycle.
// Reset: arst_n clears the state machine, timer, bar and output valid, and
// loads hold_ticks and gap_ticks with 200.
module button_gesture_bar_graph #(
	parameter int BAR_LEDS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	// tick words in
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [0] button_pressed, [7:1] zero
	// result words out
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata,   // [15:0] led_pattern, [20:16] lit_count, [23:21] gesture
	// configuration writes
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);
	import bgbg_pkg::*;

	localparam int FILL_W = $clog2(BAR_LEDS + 1);
	localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(BAR_LEDS);
	localparam logic [FILL_W-1:0] FILL_SL =
		FILL_W'((PRESET_SHORT_LONG > BAR_LEDS) ? BAR_LEDS : PRESET_SHORT_LONG);
	localparam logic [FILL_W-1:0] FILL_L =
		FILL_W'((PRESET_LONG > BAR_LEDS) ? BAR_LEDS : PRESET_LONG);

	logic [TIMER_W-1:0] hold_ticks_q;
	logic [TIMER_W-1:0] gap_ticks_q;
	gest_state_t        state_q;
	gest_state_t        state_d;
	logic [TIMER_W-1:0] elapsed_q;
	logic [TIMER_W-1:0] elapsed_d;
	logic [TIMER_W-1:0] elapsed_inc;
	logic [FILL_W-1:0]  fill_q;
	logic [FILL_W-1:0]  fill_d;
	gesture_t           gest_d;
	logic               pressed;
	logic               accept;
	logic               hold_hit;
	logic               gap_hit;

	logic [BAR_LEDS-1:0]  bar_vec;
	logic [BAR_LEDS+15:0] bar_ext;
	logic [FILL_W+4:0]    fill_ext;

	logic               out_valid_q;
	logic [23:0]        out_data_q;

	assign pressed = s_axis_tdata[0];
	assign s_axis_tready = !out_valid_q || m_axis_tready;
	assign accept = s_axis_tvalid && s_axis_tready;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_ticks_q <= TICKS_RESET;
			gap_ticks_q  <= TICKS_RESET;
		end else if (cfg_we) begin
			if (cfg_index == REG_HOLD_TICKS) begin
				hold_ticks_q <= cfg_data;
			end else if (cfg_index == REG_GAP_TICKS) begin
				gap_ticks_q <= cfg_data;
			end
		end
	end

	// saturating timer step and threshold compares
	assign elapsed_inc = (elapsed_q == TIMER_MAX) ? elapsed_q : elapsed_q + TIMER_W'(1);
	assign hold_hit = elapsed_inc >= hold_ticks_q;
	assign gap_hit  = elapsed_inc >= gap_ticks_q;

	// next state, timer and completed gesture
	always_comb begin
		state_d   = state_q;
		elapsed_d = elapsed_q;
		gest_d    = GEST_NONE;
		unique case (state_q)
			ST_PRESS1: begin
				elapsed_d = elapsed_inc;
				if (hold_hit) begin
					state_d = ST_LONG_HELD;
				end else if (!pressed) begin
					elapsed_d = '0;
					state_d   = ST_GAP_SHORT;
				end
			end
			ST_GAP_SHORT: begin
				elapsed_d = elapsed_inc;
				if (gap_hit) begin
					gest_d  = GEST_SHORT;
					state_d = ST_IDLE;
				end else if (pressed) begin
					elapsed_d = '0;
					state_d   = ST_PRESS2_S;
				end
			end
			ST_PRESS2_S: begin
				elapsed_d = elapsed_inc;
				if (hold_hit) begin
					state_d = ST_SHORT_LONG;
				end else if (!pressed) begin
					gest_d  = GEST_SHORT_SHORT;
					state_d = ST_IDLE;
				end
			end
			ST_SHORT_LONG: begin
				if (!pressed) begin
					gest_d  = GEST_SHORT_LONG;
					state_d = ST_IDLE;
				end
			end
			ST_LONG_HELD: begin
				if (!pressed) begin
					elapsed_d = '0;
					state_d   = ST_GAP_LONG;
				end
			end
			ST_GAP_LONG: begin
				elapsed_d = elapsed_inc;
				if (gap_hit) begin
					gest_d  = GEST_LONG;
					state_d = ST_IDLE;
				end else if (pressed) begin
					elapsed_d = '0;
					state_d   = ST_PRESS2_L;
				end
			end
			ST_PRESS2_L: begin
				elapsed_d = elapsed_inc;
				if (hold_hit) begin
					state_d = ST_LONG_LONG;
				end else if (!pressed) begin
					gest_d  = GEST_LONG_SHORT;
					state_d = ST_IDLE;
				end
			end
			ST_LONG_LONG: begin
				if (!pressed) begin
					gest_d  = GEST_LONG_LONG;
					state_d = ST_IDLE;
				end
			end
			default: begin
				if (pressed) begin
					elapsed_d = '0;
					state_d   = ST_PRESS1;
				end else begin
					state_d = ST_IDLE;
				end
			end
		endcase
	end

	// bar fill update from the completed gesture
	always_comb begin
		fill_d = fill_q;
		case (gest_d)
			GEST_SHORT:       if (fill_q < FILL_FULL) fill_d = fill_q + FILL_W'(1);
			GEST_SHORT_SHORT: if (fill_q != '0) fill_d = fill_q - FILL_W'(1);
			GEST_SHORT_LONG:  fill_d = FILL_SL;
			GEST_LONG:        fill_d = FILL_L;
			GEST_LONG_SHORT:  fill_d = FILL_FULL;
			GEST_LONG_LONG:   fill_d = '0;
			default:          fill_d = fill_q;
		endcase
	end

	// thermometer pattern, filled from the top bit down
	for (genvar i = 0; i < BAR_LEDS; i++) begin : g_bar
		assign bar_vec[i] = fill_d >= FILL_W'(BAR_LEDS - i);
	end
	assign bar_ext  = {16'b0, bar_vec};
	assign fill_ext = {5'b0, fill_d};

	// classifier state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			elapsed_q <= '0;
			fill_q    <= '0;
		end else if (accept) begin
			state_q   <= state_d;
			elapsed_q <= elapsed_d;
			fill_q    <= fill_d;
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s_axis_tready) begin
			out_valid_q <= s_axis_tvalid;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (accept) begin
			out_data_q <= {gest_d, fill_ext[4:0], bar_ext[15:0]};
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

endmodule

@@ dv/bgbg_bar_checker.sv @@
`timescale 1ns / 1ps
// bgbg_bar_checker: watches the tick, result and configuration ports of the
// gesture bar graph, predicts each result word and compares it field by field
// depends on bgbg_pkg for the state and gesture codes and register indexes
module bgbg_bar_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [7:0]  in_data,    // [0] button_pressed, [7:1] zero
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [23:0] out_data,   // [15:0] led_pattern, [20:16] lit_count, [23:21] gesture
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data,
	output int          pending,
	output int          fail_count
);
	import bgbg_pkg::*;

	localparam int BAR_LEDS = 16;
	localparam logic [15:0] LED_ALL = 16'hFFFF;
	localparam int REPORT_LIMIT = 10;

	// one result word, laid out as on the bus
	typedef struct packed {
		gesture_t    gesture;
		logic [4:0]  lit_count;
		logic [15:0] led_pattern;
	} bar_word_t;

	// shadow of the classifier state and thresholds
	gest_state_t gstate;
	logic [15:0] elapsed;
	logic [15:0] hold_ticks;
	logic [15:0] gap_ticks;
	logic [4:0]  fill;
	bar_word_t   bar_words_due[$];

	// saturating elapsed-tick timer
	function automatic void advance_timer();
		if (elapsed != TIMER_MAX)
			elapsed = elapsed + 16'd1;
	endfunction

	// one tick through the gesture machine, then the bar update
	function automatic bar_word_t classify_tick(input logic pressed);
		gesture_t    done;
		gest_state_t nxt;
		bar_word_t   w;
		done = GEST_NONE;
		nxt = gstate;
		case (gstate)
			ST_PRESS1: begin
				advance_timer();
				if (elapsed >= hold_ticks) begin
					nxt = ST_LONG_HELD;
				end else if (!pressed) begin
					elapsed = '0;
					nxt = ST_GAP_SHORT;
				end
			end
			ST_GAP_SHORT: begin
				// expiry wins over a press on the same tick
				advance_timer();
				if (elapsed >= gap_ticks) begin
					done = GEST_SHORT;
					nxt = ST_IDLE;
				end else if (pressed) begin
					elapsed = '0;
					nxt = ST_PRESS2_S;
				end
			end
			ST_PRESS2_S: begin
				advance_timer();
				if (elapsed >= hold_ticks) begin
					nxt = ST_SHORT_LONG;
				end else if (!pressed) begin
					done = GEST_SHORT_SHORT;
					nxt = ST_IDLE;
				end
			end
			ST_SHORT_LONG: begin
				if (!pressed) begin
					done = GEST_SHORT_LONG;
					nxt = ST_IDLE;
				end
			end
			ST_LONG_HELD: begin
				if (!pressed) begin
					elapsed = '0;
					nxt = ST_GAP_LONG;
				end
			end
			ST_GAP_LONG: begin
				advance_timer();
				if (elapsed >= gap_ticks) begin
					done = GEST_LONG;
					nxt = ST_IDLE;
				end else if (pressed) begin
					elapsed = '0;
					nxt = ST_PRESS2_L;
				end
			end
			ST_PRESS2_L: begin
				advance_timer();
				if (elapsed >= hold_ticks) begin
					nxt = ST_LONG_LONG;
				end else if (!pressed) begin
					done = GEST_LONG_SHORT;
					nxt = ST_IDLE;
				end
			end
			ST_LONG_LONG: begin
				if (!pressed) begin
					done = GEST_LONG_LONG;
					nxt = ST_IDLE;
				end
			end
			default: begin
				if (pressed) begin
					elapsed = '0;
					nxt = ST_PRESS1;
				end else begin
					nxt = ST_IDLE;
				end
			end
		endcase
		gstate = nxt;

		// bar graph reacts to the finished gesture
		case (done)
			GEST_SHORT:       if (fill < BAR_LEDS) fill = fill + 5'd1;
			GEST_SHORT_SHORT: if (fill > 0) fill = fill - 5'd1;
			GEST_SHORT_LONG:
				fill = 5'((PRESET_SHORT_LONG > BAR_LEDS) ? BAR_LEDS : PRESET_SHORT_LONG);
			GEST_LONG:        fill = 5'((PRESET_LONG > BAR_LEDS) ? BAR_LEDS : PRESET_LONG);
			GEST_LONG_SHORT:  fill = 5'(BAR_LEDS);
			GEST_LONG_LONG:   fill = '0;
			default: ;
		endcase

		w.gesture = done;
		w.lit_count = fill;
		w.led_pattern = ~(LED_ALL >> fill);
		return w;
	endfunction

	// predict on accepted ticks, compare on accepted results, track writes
	always @(posedge clk or negedge arst_n) begin
		bar_word_t got;
		bar_word_t want;
		if (!arst_n) begin
			gstate = ST_IDLE;
			elapsed = '0;
			fill = '0;
			hold_ticks = TICKS_RESET;
			gap_ticks = TICKS_RESET;
			bar_words_due.delete();
			fail_count = 0;
		end else begin
			if (in_valid && in_ready)
				bar_words_due.push_back(classify_tick(in_data[0]));
			if (out_valid && out_ready) begin
				got = out_data;
				if (bar_words_due.size() == 0) begin
					if (fail_count < REPORT_LIMIT)
						$display("%0t: result word with none expected: %s %h lit %0d gesture %0d",
							$realtime, "led", got.led_pattern, got.lit_count,
							got.gesture);
					fail_count++;
				end else begin
					want = bar_words_due.pop_front();
					if (got.led_pattern !== want.led_pattern ||
						got.lit_count !== want.lit_count ||
						got.gesture !== want.gesture) begin
						if (fail_count < REPORT_LIMIT)
							$display({"%0t: result word mismatch: ",
								"expected led %h lit %0d gesture %0d, ",
								"got led %h lit %0d gesture %0d"},
								$realtime, want.led_pattern, want.lit_count,
								want.gesture, got.led_pattern, got.lit_count,
								got.gesture);
						fail_count++;
					end
				end
			end
			if (cfg_we) begin
				case (cfg_index)
					REG_HOLD_TICKS: hold_ticks = cfg_data;
					REG_GAP_TICKS:  gap_ticks = cfg_data;
					default: ;
				endcase
			end
		end
		pending = bar_words_due.size();
	end

endmodule

@@ dv/button_gesture_bar_graph_test.sv @@
`timescale 1ns / 1ps
// button_gesture_bar_graph_test: drives button tick words and threshold writes
// into the gesture bar graph and gives the verdict from bgbg_bar_checker
// depends on bgbg_pkg, button_gesture_bar_graph and bgbg_bar_checker
module button_gesture_bar_graph_test;
	import bgbg_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int N_PHASES = 11;
	localparam int LONG_HOLD_CYCLES = 250;
	localparam int DRAIN_CYCLES = 10;
	// indexes with no register behind them
	localparam logic [1:0] REG_SPARE_LO = 2'd2;
	localparam logic [1:0] REG_SPARE_HI = 2'd3;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;
	logic        m_tvalid;
	logic        m_tready;
	logic [23:0] m_tdata;
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [15:0] cfg_data;
	int          pending;
	int          fail_count;

	int idle_pct;
	int stall_pct;
	bit hold_off_req;
	int ticks_sent;

	button_gesture_bar_graph i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_tvalid),
		.s_axis_tready (s_tready),
		.s_axis_tdata  (s_tdata),
		.m_axis_tvalid (m_tvalid),
		.m_axis_tready (m_tready),
		.m_axis_tdata  (m_tdata),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	bgbg_bar_checker i_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.in_data    (s_tdata),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_data   (m_tdata),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.pending    (pending),
		.fail_count (fail_count)
	);

	// 12 ns clock
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// run limit
	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("button_gesture_bar_graph_test failed");
		$finish;
	end

	// result side: random stall bursts plus one long hold-off on request
	initial begin
		int stall_left;
		stall_left = 0;
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_off_req) begin
				hold_off_req = 1'b0;
				stall_left = LONG_HOLD_CYCLES;
			end else if (stall_left == 0 && stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
				stall_left = $urandom_range(1, 15);
			end
			if (stall_left > 0) begin
				m_tready <= 1'b0;
				stall_left--;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// one tick word, with an optional idle burst ahead of it
	task automatic send_tick(input logic pressed);
		if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 15)) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {7'd0, pressed};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		@(negedge clk);
		ticks_sent++;
	endtask

	// drop valid and wait until every result word is back
	task automatic settle();
		s_tvalid <= 1'b0;
		do @(negedge clk); while (pending != 0);
	endtask

	// both thresholds, then a write to an unused index that must change nothing
	task automatic program_thresholds(input logic [15:0] hold_val, input logic [15:0] gap_val);
		cfg_we <= 1'b1;
		cfg_index <= REG_HOLD_TICKS;
		cfg_data <= hold_val;
		@(negedge clk);
		cfg_index <= REG_GAP_TICKS;
		cfg_data <= gap_val;
		@(negedge clk);
		cfg_index <= $urandom_range(0, 1) ? REG_SPARE_LO : REG_SPARE_HI;
		cfg_data <= 16'($urandom);
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// duration clustered around a threshold so both sides of it get hit, or a short one for thresholds above 300
	function automatic int pick_len(input int th);
		int t;
		t = (th < 1) ? 1 : th;
		if (t > 300)
			return $urandom_range(1, 12);
		case ($urandom_range(0, 3))
			0: return $urandom_range(1, t);
			1: return $urandom_range((t > 1) ? t - 1 : 1, t + 1);
			2: return $urandom_range(t, t + 4);
			default: return 1;
		endcase
	endfunction

	// one or two presses, each followed by a release
	task automatic play_gesture(input int hold_val, input int gap_val);
		repeat ($urandom_range(1, 2)) begin
			repeat (pick_len(hold_val)) send_tick(1'b1);
			repeat (pick_len(gap_val)) send_tick(1'b0);
		end
	endtask

	// stimulus and verdict
	initial begin
		string directed_ticks;
		int budget;
		logic [15:0] hold_val;
		logic [15:0] gap_val;
		bit quiet;

		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		cfg_we = 1'b0;
		cfg_index = REG_HOLD_TICKS;
		cfg_data = '0;
		idle_pct = 0;
		stall_pct = 0;
		hold_off_req = 1'b0;
		ticks_sent = 0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed gestures with both thresholds at two ticks: short-short from
		// an empty bar, short-long, release on the long threshold tick then
		// long-short, long-long, press on the short gap expiry, press on the long
		// gap expiry
		directed_ticks = {"1010", "101110", "110010", "11101110", "1001", "111001"};
		idle_pct = 20;
		stall_pct = 20;
		program_thresholds(16'd2, 16'd2);
		for (int i = 0; i < directed_ticks.len(); i++)
			send_tick(directed_ticks[i] == "1");
		settle();

		// random phases: reset thresholds, extremes, then small random ones, but for one phase with a wide-range hold
		for (int ph = 0; ph < N_PHASES; ph++) begin
			budget = 95;
			case (ph)
				0: begin
					hold_val = TICKS_RESET;
					gap_val = TICKS_RESET;
					budget = 150;
				end
				1: begin
					hold_val = 16'd1;
					gap_val = 16'd1;
				end
				2: begin
					hold_val = 16'd0;
					gap_val = 16'd0;
				end
				3: begin
					hold_val = TIMER_MAX;
					gap_val = 16'd1;
				end
				4: begin
					hold_val = 16'd1;
					gap_val = TIMER_MAX;
				end
				6: begin
					hold_val = 16'($urandom_range(1, 65535));
					gap_val = 16'($urandom_range(2, 12));
				end
				default: begin
					hold_val = 16'($urandom_range(2, 12));
					gap_val = 16'($urandom_range(2, 12));
				end
			endcase
			quiet = (ph >= N_PHASES - 2);
			case ($urandom_range(0, 3))
				0: idle_pct = 0;
				1: idle_pct = 5;
				2: idle_pct = 20;
				default: idle_pct = 40;
			endcase
			stall_pct = $urandom_range(0, 1) ? 0 : $urandom_range(5, 40);
			if (quiet) begin
				idle_pct = 0;
				stall_pct = 0;
			end
			program_thresholds(hold_val, gap_val);
			// back up the result side while ticks keep coming
			if (ph == 5)
				hold_off_req = 1'b1;
			ticks_sent = 0;
			while (ticks_sent < budget) begin
				if ($urandom_range(0, 4) == 0) begin
					repeat ($urandom_range(1, 8)) send_tick(1'($urandom_range(0, 1)));
				end else begin
					play_gesture(hold_val, gap_val);
				end
			end
			settle();
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("button_gesture_bar_graph_test passed");
		else
			$display("button_gesture_bar_graph_test failed");
		$finish;
	end

endmodule

@@ filelist.f @@
rtl/core/bgbg_pkg.sv
rtl/core/button_gesture_bar_graph.sv
dv/bgbg_bar_checker.sv
dv/button_gesture_bar_graph_test.sv
